@@ rtl/rsd_pkg.sv @@
`timescale 1ns / 1ps
package rsd_pkg;

   localparam logic [7:0] HDR_A       = 8'h53;
   localparam logic [7:0] HDR_B       = 8'h59;
   localparam logic [7:0] END_A       = 8'h54;
   localparam logic [7:0] END_B       = 8'h43;
   localparam logic [7:0] FALL_TYPE   = 8'h83;
   localparam logic [7:0] FALL_SUB    = 8'h01;
   localparam logic [7:0] FALL_FLAG   = 8'h01;
   localparam logic [7:0] MOVE_TYPE   = 8'h80;
   localparam logic [7:0] MOVE_SUB    = 8'h03;
   localparam logic [7:0] MOVE_LEN_HI = 8'h00;
   localparam logic [7:0] MOVE_LEN_LO = 8'h01;
   localparam logic [7:0] STILL_BELOW = 8'd5;
   localparam logic [7:0] CLASS_LEN   = 8'd10;

   // first and last kept body position of a frame
   localparam int BODY_FIRST = 2;
   localparam int BODY_LAST  = 7;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] EV_NONE = 2'd0;
   localparam logic [1:0] EV_FALL = 2'd1;
   localparam logic [1:0] EV_MOVE = 2'd2;

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_FALL = 2'd1,
      OP_MOVE = 2'd2,
      OP_OVF  = 2'd3
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  value;
   } op_type;

   typedef struct packed {
      logic   push;
      op_type op;
   } push_type;

   typedef struct packed {
      logic   valid;
      logic   full;
      op_type op;
   } queue_status_type;

endpackage

@@ rtl/rsd_if.sv @@
`timescale 1ns / 1ps
interface rsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface rsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] frame_event;
   logic [7:0] movement_value;
   logic       stillness_alarm;
   logic       frame_overflow;
   modport source (output valid, output frame_event, output movement_value,
                   output stillness_alarm, output frame_overflow, input ready);
   modport sink (input valid, input frame_event, input movement_value,
                 input stillness_alarm, input frame_overflow, output ready);
endinterface

interface rsd_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/radar_frame_stillness_detector.sv @@
`timescale 1ns / 1ps
// channel    dir   payload                                        transaction
// req_chan   in    rx_byte[7:0]                                   one serial byte
// rsp_chan   out   frame_event[1:0] movement_value[7:0]           one result per byte
//                  stillness_alarm frame_overflow
// csr_chan   in    data[7:0] (stillness_target)                   one target write
//
// One byte is taken per cycle while the op queue is not full; its result passes through the
// front framer, the two-entry op queue and the back run counter with its output register.
// Reset is synchronous: hunting state, run counter and target go to zero.
// A stalled rsp_chan fills the output register and then the queue; req_chan.ready
// drops only when the queue is full. csr_chan is always ready.
module radar_frame_stillness_detector #(
   parameter int MAX_FRAME_BYTES = 128,
   parameter int HISTORY_LIMIT   = 200
) (
   input  logic      clock,
   input  logic      reset,
   rsd_req_if.sink   req_chan,
   rsd_rsp_if.source rsp_chan,
   rsd_csr_if.sink   csr_chan
);

   rsd_pkg::push_type         q_push;
   rsd_pkg::queue_status_type q_status;
   logic                      pop;

   rsd_front #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .q_status (q_status),
      .q_push   (q_push)
   );

   rsd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .pop      (pop),
      .q_status (q_status)
   );

   rsd_back #(
      .HISTORY_LIMIT(HISTORY_LIMIT)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .pop      (pop),
      .csr      (csr_chan),
      .rsp      (rsp_chan)
   );

endmodule

@@ rtl/rsd_front.sv @@
`timescale 1ns / 1ps
module rsd_front #(
   parameter int MAX_FRAME_BYTES = 128
) (
   input  logic                      clock,
   input  logic                      reset,
   rsd_req_if.sink                   req,
   input  rsd_pkg::queue_status_type q_status,
   output rsd_pkg::push_type         q_push
);

   localparam logic [7:0] MAX_LEN = 8'(MAX_FRAME_BYTES);

   logic       in_frame_ff, in_frame_in;
   logic [7:0] prev_ff, prev_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] body_ff [rsd_pkg::BODY_FIRST:rsd_pkg::BODY_LAST];
   logic       accept;
   logic [7:0] len_next;
   logic       tail_seen;
   logic       is_fall;
   logic       is_move;
   rsd_pkg::op_type op;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;
   assign len_next  = len_ff + 8'd1;
   assign tail_seen = (prev_ff == rsd_pkg::END_A) && (req.rx_byte == rsd_pkg::END_B);

   // a frame of ten or more bytes has written every kept body position
   assign is_fall = (len_next >= rsd_pkg::CLASS_LEN) &&
                    (body_ff[2] == rsd_pkg::FALL_TYPE) &&
                    (body_ff[3] == rsd_pkg::FALL_SUB) &&
                    (body_ff[6] == rsd_pkg::FALL_FLAG);
   assign is_move = (len_next == rsd_pkg::CLASS_LEN) &&
                    (body_ff[2] == rsd_pkg::MOVE_TYPE) &&
                    (body_ff[3] == rsd_pkg::MOVE_SUB) &&
                    (body_ff[4] == rsd_pkg::MOVE_LEN_HI) &&
                    (body_ff[5] == rsd_pkg::MOVE_LEN_LO);

   always_comb begin
      in_frame_in = in_frame_ff;
      len_in      = len_ff;
      prev_in     = req.rx_byte;
      op.kind     = rsd_pkg::OP_NONE;
      op.value    = 8'd0;
      if (!in_frame_ff) begin
         if (prev_ff == rsd_pkg::HDR_A && req.rx_byte == rsd_pkg::HDR_B) begin
            in_frame_in = 1'b1;
            len_in      = 8'd2;
         end
      end else if (len_ff >= MAX_LEN) begin
         in_frame_in = 1'b0;
         len_in      = 8'd0;
         op.kind     = rsd_pkg::OP_OVF;
      end else begin
         len_in = len_next;
         if (tail_seen) begin
            in_frame_in = 1'b0;
            len_in      = 8'd0;
            if (is_fall) begin
               op.kind = rsd_pkg::OP_FALL;
            end else if (is_move) begin
               op.kind  = rsd_pkg::OP_MOVE;
               op.value = body_ff[6];
            end
         end
      end
   end

   assign q_push.push = accept;
   assign q_push.op   = op;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         prev_ff     <= 8'd0;
         len_ff      <= 8'd0;
      end else if (accept) begin
         in_frame_ff <= in_frame_in;
         prev_ff     <= prev_in;
         len_ff      <= len_in;
      end
   end

   // keep body bytes at their frame positions
   always_ff @(posedge clock) begin
      if (accept && in_frame_ff && len_ff < MAX_LEN) begin
         for (int i = rsd_pkg::BODY_FIRST; i <= rsd_pkg::BODY_LAST; i++) begin
            if (len_ff == 8'(i)) begin
               body_ff[i] <= req.rx_byte;
            end
         end
      end
   end

endmodule

@@ rtl/rsd_queue.sv @@
`timescale 1ns / 1ps
module rsd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  rsd_pkg::push_type         q_push,
   input  logic                      pop,
   output rsd_pkg::queue_status_type q_status
);

   rsd_pkg::op_type                 mem [rsd_pkg::QUEUE_DEPTH];
   logic [rsd_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [rsd_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [rsd_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                            do_push;
   logic                            do_pop;

   localparam logic [rsd_pkg::QPTR_W-1:0] LAST_PTR = rsd_pkg::QPTR_W'(rsd_pkg::QUEUE_DEPTH - 1);
   localparam logic [rsd_pkg::QCNT_W-1:0] FULL_CNT = rsd_pkg::QCNT_W'(rsd_pkg::QUEUE_DEPTH);

   assign q_status.valid = (count_ff != '0);
   assign q_status.full  = (count_ff == FULL_CNT);
   assign q_status.op    = mem[rd_ptr_ff];

   assign do_push = q_push.push && !q_status.full;
   assign do_pop  = pop && q_status.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= q_push.op;
      end
   end

endmodule

@@ rtl/rsd_back.sv @@
`timescale 1ns / 1ps
module rsd_back #(
   parameter int HISTORY_LIMIT = 200
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rsd_pkg::queue_status_type q_status,
   output logic                      pop,
   rsd_csr_if.sink                   csr,
   rsd_rsp_if.source                 rsp
);

   localparam logic [7:0] HIST_LIM = 8'(HISTORY_LIMIT);

   logic       rsp_valid_ff;
   logic [1:0] event_ff, event_in;
   logic [7:0] value_ff, value_in;
   logic       alarm_ff, alarm_in;
   logic       ovf_ff, ovf_in;
   logic [7:0] target_ff;
   logic [7:0] run_ff, run_in;
   logic [7:0] run_step;
   logic       hit;
   logic       csr_write;

   assign csr.ready = 1'b1;
   assign csr_write = csr.valid && csr.ready;

   assign pop = q_status.valid && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      run_step = 8'd0;
      if (q_status.op.value < rsd_pkg::STILL_BELOW) begin
         run_step = (run_ff < HIST_LIM) ? run_ff + 8'd1 : run_ff;
      end
   end

   assign hit = (target_ff != 8'd0) && (target_ff <= HIST_LIM) && (run_step >= target_ff);

   always_comb begin
      event_in = rsd_pkg::EV_NONE;
      value_in = 8'd0;
      alarm_in = 1'b0;
      ovf_in   = 1'b0;
      run_in   = run_ff;
      case (q_status.op.kind)
         rsd_pkg::OP_FALL: begin
            event_in = rsd_pkg::EV_FALL;
         end
         rsd_pkg::OP_MOVE: begin
            event_in = rsd_pkg::EV_MOVE;
            value_in = q_status.op.value;
            alarm_in = hit;
            run_in   = hit ? 8'd0 : run_step;
         end
         rsd_pkg::OP_OVF: begin
            ovf_in = 1'b1;
         end
         default: begin
            event_in = rsd_pkg::EV_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         target_ff    <= 8'd0;
         run_ff       <= 8'd0;
      end else begin
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // a target write clears the run
         if (csr_write) begin
            target_ff <= csr.data;
            run_ff    <= 8'd0;
         end else if (pop) begin
            run_ff <= run_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         event_ff <= event_in;
         value_ff <= value_in;
         alarm_ff <= alarm_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.frame_event     = event_ff;
   assign rsp.movement_value  = value_ff;
   assign rsp.stillness_alarm = alarm_ff;
   assign rsp.frame_overflow  = ovf_ff;

endmodule

@@ verif/rsd_checker.sv @@
`timescale 1ns / 1ps
module rsd_checker #(
   parameter int MAX_FRAME_BYTES = 128,
   parameter int HISTORY_LIMIT   = 200
) (
   input  logic clock,
   input  logic reset,
   rsd_req_if   req_chan,
   rsd_rsp_if   rsp_chan,
   rsd_csr_if   csr_chan,
   output int   outstanding,
   output int   error_count
);

   typedef struct packed {
      logic [1:0] frame_event;
      logic [7:0] movement_value;
      logic       stillness_alarm;
      logic       frame_overflow;
   } report_type;

   report_type awaited_reports[$];

   // shadow of the framer and the still-run counter
   logic       in_frame;
   logic [7:0] last_byte;
   int         frame_len;
   logic [7:0] frame_body[8];
   logic [7:0] still_run;
   logic [7:0] still_target;
   int         mismatches = 0;

   task automatic parse_byte(input logic [7:0] b, output report_type rpt);
      logic [7:0] level;
      rpt = '0;
      if (!in_frame) begin
         if (last_byte == rsd_pkg::HDR_A && b == rsd_pkg::HDR_B) begin
            in_frame  = 1'b1;
            frame_len = 2;
         end
      end else if (frame_len >= MAX_FRAME_BYTES) begin
         // drop the frame; this byte cannot open a new header
         in_frame           = 1'b0;
         frame_len          = 0;
         rpt.frame_overflow = 1'b1;
      end else begin
         if (frame_len < 8) frame_body[frame_len] = b;
         frame_len++;
         if (last_byte == rsd_pkg::END_A && b == rsd_pkg::END_B) begin
            if (frame_len >= rsd_pkg::CLASS_LEN &&
                frame_body[2] == rsd_pkg::FALL_TYPE &&
                frame_body[3] == rsd_pkg::FALL_SUB &&
                frame_body[6] == rsd_pkg::FALL_FLAG) begin
               rpt.frame_event = rsd_pkg::EV_FALL;
            end else if (frame_len == rsd_pkg::CLASS_LEN &&
                         frame_body[2] == rsd_pkg::MOVE_TYPE &&
                         frame_body[3] == rsd_pkg::MOVE_SUB &&
                         frame_body[4] == rsd_pkg::MOVE_LEN_HI &&
                         frame_body[5] == rsd_pkg::MOVE_LEN_LO) begin
               level              = frame_body[6];
               rpt.frame_event    = rsd_pkg::EV_MOVE;
               rpt.movement_value = level;
               if (level < rsd_pkg::STILL_BELOW) begin
                  if (still_run < HISTORY_LIMIT) still_run++;
               end else begin
                  still_run = '0;
               end
               if (still_target != 0 && still_target <= HISTORY_LIMIT &&
                   still_run >= still_target) begin
                  rpt.stillness_alarm = 1'b1;
                  still_run           = '0;
               end
            end
            in_frame  = 1'b0;
            frame_len = 0;
         end
      end
      last_byte = b;
   endtask

   task automatic check_report();
      report_type got;
      report_type want;
      got.frame_event     = rsp_chan.frame_event;
      got.movement_value  = rsp_chan.movement_value;
      got.stillness_alarm = rsp_chan.stillness_alarm;
      got.frame_overflow  = rsp_chan.frame_overflow;
      if (awaited_reports.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected report: ev=%0d mv=%0d alarm=%0d ovf=%0d",
                     got.frame_event, got.movement_value, got.stillness_alarm,
                     got.frame_overflow);
      end else begin
         want = awaited_reports.pop_front();
         if (got.frame_event !== want.frame_event ||
             got.movement_value !== want.movement_value ||
             got.stillness_alarm !== want.stillness_alarm ||
             got.frame_overflow !== want.frame_overflow) begin
            mismatches++;
            if (mismatches <= 10)
               $display("report mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                        want.frame_event, want.movement_value, want.stillness_alarm,
                        want.frame_overflow, got.frame_event, got.movement_value,
                        got.stillness_alarm, got.frame_overflow);
         end
      end
   endtask

   always @(posedge clock) begin
      report_type fresh;
      if (reset) begin
         awaited_reports.delete();
         in_frame     = 1'b0;
         last_byte    = '0;
         frame_len    = 0;
         still_run    = '0;
         still_target = '0;
         for (int i = 0; i < 8; i++) frame_body[i] = '0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            still_target = csr_chan.data;
            still_run    = '0;
         end
         if (rsp_chan.valid && rsp_chan.ready) check_report();
         if (req_chan.valid && req_chan.ready) begin
            parse_byte(req_chan.rx_byte, fresh);
            awaited_reports.push_back(fresh);
         end
      end
      outstanding <= awaited_reports.size();
      error_count <= mismatches;
   end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
module tb;

   localparam int MAX_FRAME_BYTES = 128;
   localparam int HISTORY_LIMIT   = 200;
   localparam int DRAIN_CYCLES    = 16;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int PHASE_BYTES     = 120;

   typedef logic [7:0] byte_q_type[$];

   logic clock;
   logic reset;
   int   outstanding;
   int   error_count;
   int   quiet_cycles;
   bit   calm = 1'b0;
   bit   gaps_on;

   rsd_req_if req_chan ();
   rsd_rsp_if rsp_chan ();
   rsd_csr_if csr_chan ();

   radar_frame_stillness_detector #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
      .HISTORY_LIMIT  (HISTORY_LIMIT)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   rsd_checker #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
      .HISTORY_LIMIT  (HISTORY_LIMIT)
   ) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_chan   (csr_chan),
      .outstanding(outstanding),
      .error_count(error_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // result side: ready runs of random length, broken by stalls
   initial begin
      rsp_chan.ready = 1'b0;
      wait (!reset);
      forever begin
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         if (!calm && $urandom_range(0, 1) == 1) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
      end
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             (csr_chan.valid && csr_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("tb NOT OK");
      $finish;
   end

   function automatic logic [7:0] rnd_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] activity_value();
      int pick = $urandom_range(0, 9);
      if (pick < 6) return 8'($urandom_range(0, rsd_pkg::STILL_BELOW - 1));
      if (pick == 6) return rsd_pkg::STILL_BELOW;
      if (pick == 7) return 8'hff;
      return rnd_byte();
   endfunction

   function automatic byte_q_type movement_frame(input logic [7:0] level);
      byte_q_type q;
      q = {rsd_pkg::HDR_A, rsd_pkg::HDR_B, rsd_pkg::MOVE_TYPE, rsd_pkg::MOVE_SUB,
           rsd_pkg::MOVE_LEN_HI, rsd_pkg::MOVE_LEN_LO, level, rnd_byte(),
           rsd_pkg::END_A, rsd_pkg::END_B};
      return q;
   endfunction

   function automatic byte_q_type fall_frame();
      byte_q_type q;
      q = {rsd_pkg::HDR_A, rsd_pkg::HDR_B, rsd_pkg::FALL_TYPE, rsd_pkg::FALL_SUB,
           rnd_byte(), rnd_byte(), rsd_pkg::FALL_FLAG, rnd_byte()};
      repeat ($urandom_range(0, 3)) q.push_back(rnd_byte());
      q.push_back(rsd_pkg::END_A);
      q.push_back(rsd_pkg::END_B);
      return q;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      if (!calm && gaps_on && $urandom_range(0, 9) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_bytes(input byte_q_type q);
      gaps_on = $urandom_range(0, 1);
      foreach (q[i]) send_byte(q[i]);
   endtask

   // lower valid at the last transaction and wait for every report
   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_target(input logic [7:0] target);
      drain();
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= target;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic run_random(input int budget);
      byte_q_type q;
      int         sent;
      int         pick;
      int         pos;
      logic [7:0] b;
      sent = 0;
      while (sent < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            q = movement_frame(activity_value());
         end else if (pick < 65) begin
            q = fall_frame();
         end else if (pick < 78) begin
            q = {};
            repeat ($urandom_range(1, 6)) q.push_back(rnd_byte());
            if ($urandom_range(0, 4) == 0) q.push_back(rsd_pkg::HDR_A);
         end else if (pick < 98) begin
            q = movement_frame(rnd_byte());
            case ($urandom_range(0, 4))
               0: q[$urandom_range(2, 7)] = rnd_byte();
               1: q.delete($urandom_range(2, 7));
               2: begin
                  // header bytes inside a frame are plain data
                  pos = $urandom_range(2, 8);
                  q.insert(pos, rsd_pkg::HDR_B);
                  q.insert(pos, rsd_pkg::HDR_A);
               end
               3: begin
                  q = fall_frame();
                  q[$urandom_range(2, 6)] = rnd_byte();
               end
               default: begin
                  q = {rsd_pkg::HDR_A, rsd_pkg::HDR_B};
                  repeat ($urandom_range(0, 12)) q.push_back(rnd_byte());
                  q.push_back(rsd_pkg::END_A);
                  q.push_back(rsd_pkg::END_B);
               end
            endcase
         end else begin
            // frame lengths around the buffer limit
            q = {rsd_pkg::HDR_A, rsd_pkg::HDR_B};
            repeat ($urandom_range(MAX_FRAME_BYTES - 4, MAX_FRAME_BYTES - 1)) begin
               b = rnd_byte();
               if (b == rsd_pkg::END_A) b = 8'h00;
               q.push_back(b);
            end
            q.push_back(rsd_pkg::END_A);
            q.push_back(rsd_pkg::END_B);
         end
         send_bytes(q);
         sent += q.size();
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = '0;
      csr_chan.valid   = 1'b0;
      csr_chan.data    = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, each frame kind, early close, header inside a frame
      send_bytes({8'h00, 8'hff, rsd_pkg::HDR_A, 8'h00, rsd_pkg::HDR_B});
      send_bytes(movement_frame(8'h00));
      send_bytes(movement_frame(8'hff));
      send_bytes(fall_frame());
      send_bytes({rsd_pkg::HDR_A, rsd_pkg::HDR_B, rsd_pkg::END_A, rsd_pkg::END_B});
      send_bytes({rsd_pkg::HDR_A, rsd_pkg::HDR_B, rsd_pkg::HDR_A, rsd_pkg::HDR_B,
                  rsd_pkg::MOVE_TYPE, rsd_pkg::MOVE_SUB, rsd_pkg::MOVE_LEN_HI,
                  rsd_pkg::MOVE_LEN_LO, 8'h02, 8'h00, rsd_pkg::END_A, rsd_pkg::END_B});

      write_target(8'd1);
      run_random(PHASE_BYTES);
      write_target(8'd3);
      run_random(PHASE_BYTES);

      // a long run of still reports
      write_target(8'd50);
      repeat (64)
         send_bytes(movement_frame(8'($urandom_range(0, rsd_pkg::STILL_BELOW - 1))));

      write_target(8'hff);
      run_random(PHASE_BYTES);
      write_target(8'(HISTORY_LIMIT + 1));
      run_random(PHASE_BYTES);
      write_target(8'd0);
      run_random(PHASE_BYTES);
      write_target(8'($urandom_range(2, 12)));
      run_random(PHASE_BYTES);

      write_target(8'd2);
      calm = 1'b1;
      run_random(PHASE_BYTES);

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && outstanding == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/rsd_pkg.sv
rtl/rsd_if.sv
rtl/rsd_front.sv
rtl/rsd_queue.sv
rtl/rsd_back.sv
rtl/radar_frame_stillness_detector.sv
verif/rsd_checker.sv
verif/tb.sv
